// File: hdl/rtpci_pkg.sv
// rtpci_pkg: shared constants, fixed-point widths, fit coefficients and
// controller/datapath command types for the rate to pwm cubic inverse block.
// No dependencies.
package rtpci_pkg;

    localparam int ITERATIONS    = 24;
    localparam int FRACTION_BITS = 16;

    // bracket and midpoint: unsigned, up to 256.0
    localparam int X_W    = 9 + FRACTION_BITS;
    // horner accumulator in q32
    localparam int T_W    = 48;
    localparam int TL_W   = 24;
    localparam int TH_W   = T_W - TL_W;
    localparam int PL_W   = TL_W + X_W;
    localparam int PH_W   = TH_W + X_W + 1;
    localparam int S_W    = T_W + X_W + 1;
    // rate magnitude in q32
    localparam int Y_W    = 64 - FRACTION_BITS;
    localparam int D_W    = ((T_W > Y_W) ? T_W : Y_W) + 2;
    localparam int IT_W   = $clog2(ITERATIONS);

    localparam int RATE_W   = 32;
    localparam int PWM_W    = 10;
    localparam int TILT_W   = 16;
    localparam int CASE_W   = 2;
    localparam int COEF_SEL_W = 2;

    localparam longint ONE_L       = longint'(1) << FRACTION_BITS;
    localparam longint PAN_LIMIT_L = 120 * ONE_L;

    localparam logic [X_W-1:0] BRACKET_LO = X_W'(ONE_L);
    localparam logic [X_W-1:0] BRACKET_HI = X_W'(256 * ONE_L);
    localparam logic [X_W-1:0] HALF_X     = X_W'(ONE_L >> 1);
    localparam logic [TILT_W-1:0] TILT_MAX = TILT_W'(32768);

    localparam longint A3_L = 64'sd214820;
    localparam longint A2_L = 64'sd99403108;
    localparam longint A1_L = 64'sd13204204254;
    localparam longint A0_L = -64'sd9762548766;
    // fit at the top of the bracket, whole pwm so every product is exact
    localparam longint FIT_HI_L = ((A3_L * 256 - A2_L) * 256 + A1_L) * 256 + A0_L;

    localparam logic signed [T_W-1:0] COEF_A3  = T_W'(A3_L);
    localparam logic signed [T_W-1:0] COEF_NA2 = T_W'(-A2_L);
    localparam logic signed [T_W-1:0] COEF_A1  = T_W'(A1_L);
    localparam logic signed [T_W-1:0] COEF_A0  = T_W'(A0_L);
    localparam logic signed [T_W-1:0] FIT_HI   = T_W'(FIT_HI_L);

    localparam logic [COEF_SEL_W-1:0] SEL_NA2     = 2'd0;
    localparam logic [COEF_SEL_W-1:0] SEL_A1      = 2'd1;
    localparam logic [COEF_SEL_W-1:0] SEL_A0      = 2'd2;
    localparam logic [COEF_SEL_W-1:0] HORNER_LAST = SEL_A0;

    typedef enum logic [CASE_W-1:0] {
        CASE_RIGHT = 2'd0,
        CASE_LEFT  = 2'd1,
        CASE_HOLD  = 2'd2,
        CASE_RANGE = 2'd3
    } t_pan_case;

    typedef struct packed {
        logic                  load;
        logic                  mid;
        logic                  mul_lo;
        logic                  mul_hi;
        logic                  acc;
        logic                  decide;
        logic                  finish;
        logic [COEF_SEL_W-1:0] coef_sel;
    } t_cmd;

    typedef struct packed {
        logic bisect;
    } t_sts;

    function automatic logic signed [T_W-1:0] coef_of(input logic [COEF_SEL_W-1:0] sel);
        logic signed [T_W-1:0] c;
        case (sel)
            SEL_NA2: c = COEF_NA2;
            SEL_A1:  c = COEF_A1;
            default: c = COEF_A0;
        endcase
        return c;
    endfunction

endpackage

// File: hdl/rtpci_ctrl.sv
// rtpci_ctrl: sequencer for the bisection (midpoint, three horner rounds of
// split multiply, decide) and the output word valid flag. Uses rtpci_pkg.
module rtpci_ctrl import rtpci_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MID    = 7'b0000010,
        ST_LO     = 7'b0000100,
        ST_HI     = 7'b0001000,
        ST_ACC    = 7'b0010000,
        ST_DECIDE = 7'b0100000,
        ST_FIN    = 7'b1000000
    } t_state;

    t_state                r_state, n_state;
    logic [IT_W-1:0]       r_iter, n_iter;
    logic [COEF_SEL_W-1:0] r_round, n_round;
    logic                  r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_iter     = '0;
                    n_state    = ST_MID;
                end
            end
            ST_MID: begin
                o_cmd.mid = 1'b1;
                n_round   = '0;
                n_state   = i_sts.bisect ? ST_LO : ST_FIN;
            end
            ST_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_HI;
            end
            ST_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc      = 1'b1;
                o_cmd.coef_sel = r_round;
                if (r_round == HORNER_LAST) begin
                    n_state = ST_DECIDE;
                end else begin
                    n_round = r_round + 1'b1;
                    n_state = ST_LO;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (r_iter == IT_W'(ITERATIONS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_iter  = r_iter + 1'b1;
                    n_state = ST_MID;
                end
            end
            ST_FIN: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/rtpci_dp.sv
// rtpci_dp: datapath with bracket, split horner multiplier, sign test, rounding,
// held pan pwm and output word registers. Uses rtpci_pkg.
module rtpci_dp import rtpci_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_sts                     o_sts,
    input  logic signed [RATE_W-1:0] i_pan_rate,
    input  logic signed [RATE_W-1:0] i_tilt_rate,
    output logic signed [PWM_W-1:0]  o_pan_pwm,
    output logic [TILT_W-1:0]        o_tilt_pwm,
    output logic [CASE_W-1:0]        o_pan_case
);

    logic [Y_W-1:0]           r_y;
    t_pan_case                r_case;
    logic [TILT_W-1:0]        r_tilt_pwm;
    logic [X_W-1:0]           r_low, r_high, r_c;
    logic signed [T_W-1:0]    r_fh, r_t;
    logic [PL_W-1:0]          r_pl;
    logic signed [PH_W-1:0]   r_ph;
    // only the rounded held value is ever observed
    logic signed [PWM_W-1:0]  r_held_pwm, n_held_pwm;
    logic signed [PWM_W-1:0]  r_out_pan;
    logic [TILT_W-1:0]        r_out_tilt;
    t_pan_case                r_out_case;

    logic                     pan_neg;
    logic [RATE_W-1:0]        pan_mag, tilt_mag;
    t_pan_case                pan_case;
    logic [RATE_W:0]          tilt_sum, tilt_round;
    logic [TILT_W-1:0]        tilt_pwm;
    logic [X_W:0]             mid_sum, c_sum;
    logic signed [S_W-1:0]    prod_sum, prod_fl;
    logic signed [D_W-1:0]    y_d, dh, dc;
    logic                     move_low;
    logic signed [PWM_W-1:0]  c_mag;

    // input classification and tilt rounding
    always_comb begin
        pan_neg  = i_pan_rate[RATE_W-1];
        pan_mag  = pan_neg ? RATE_W'(-i_pan_rate) : RATE_W'(i_pan_rate);
        tilt_mag = i_tilt_rate[RATE_W-1] ? RATE_W'(-i_tilt_rate) : RATE_W'(i_tilt_rate);
        if (pan_mag == '0) begin
            pan_case = CASE_HOLD;
        end else if (pan_neg) begin
            pan_case = CASE_LEFT;
        end else if ((RATE_W + 1)'(pan_mag) < (RATE_W + 1)'(PAN_LIMIT_L)) begin
            pan_case = CASE_RIGHT;
        end else begin
            pan_case = CASE_RANGE;
        end
        tilt_sum   = (RATE_W + 1)'(tilt_mag) + (RATE_W + 1)'(HALF_X);
        tilt_round = tilt_sum >> FRACTION_BITS;
        tilt_pwm   = (tilt_round > (RATE_W + 1)'(TILT_MAX)) ? TILT_MAX : TILT_W'(tilt_round);
    end

    assign mid_sum  = (X_W + 1)'(r_low) + (X_W + 1)'(r_high);
    assign prod_sum = (S_W'(r_ph) <<< TL_W) + $signed(S_W'(r_pl));
    // floor of t*x scaled back to q32
    assign prod_fl  = prod_sum >>> FRACTION_BITS;

    assign y_d      = $signed(D_W'(r_y));
    assign dh       = D_W'(r_fh) - y_d;
    assign dc       = D_W'(r_t) - y_d;
    assign move_low = ((dh < 0) && (dc > 0)) || ((dh > 0) && (dc < 0));

    assign c_sum = (X_W + 1)'(r_c) + (X_W + 1)'(HALF_X);
    assign c_mag = PWM_W'(c_sum >> FRACTION_BITS);

    always_comb begin
        case (r_case)
            CASE_RIGHT: n_held_pwm = c_mag;
            CASE_LEFT:  n_held_pwm = -c_mag;
            CASE_RANGE: n_held_pwm = '0;
            default:    n_held_pwm = r_held_pwm;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_y        <= Y_W'(pan_mag) << (32 - FRACTION_BITS);
            r_case     <= pan_case;
            r_tilt_pwm <= tilt_pwm;
            r_low      <= BRACKET_LO;
            r_high     <= BRACKET_HI;
            r_fh       <= FIT_HI;
        end
        if (i_cmd.mid) begin
            r_c <= X_W'(mid_sum >> 1);
            r_t <= COEF_A3;
        end
        if (i_cmd.mul_lo) begin
            r_pl <= PL_W'(r_t[TL_W-1:0]) * PL_W'(r_c);
        end
        if (i_cmd.mul_hi) begin
            r_ph <= PH_W'($signed(r_t[T_W-1:TL_W])) * PH_W'($signed({1'b0, r_c}));
        end
        if (i_cmd.acc) begin
            r_t <= T_W'(prod_fl) + coef_of(i_cmd.coef_sel);
        end
        if (i_cmd.decide) begin
            if (move_low) begin
                r_low <= r_c;
            end else begin
                r_high <= r_c;
                r_fh   <= r_t;
            end
        end
        if (i_cmd.finish) begin
            r_out_pan  <= n_held_pwm;
            r_out_tilt <= r_tilt_pwm;
            r_out_case <= r_case;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_pwm <= '0;
        end else if (i_cmd.finish) begin
            r_held_pwm <= n_held_pwm;
        end
    end

    assign o_sts.bisect = (r_case == CASE_RIGHT) || (r_case == CASE_LEFT);
    assign o_pan_pwm    = r_out_pan;
    assign o_tilt_pwm   = r_out_tilt;
    assign o_pan_case   = r_out_case;

endmodule

// File: hdl/rate_to_pwm_cubic_inverse_top.sv
// rate_to_pwm_cubic_inverse_top: stream wrapper joining rtpci_ctrl and rtpci_dp.
// Depends on rtpci_pkg, rtpci_ctrl, rtpci_dp.
//
//  channel   dir  tdata (low bit first)                     tuser
//  s_axis    in   pan_rate[31:0], tilt_rate[63:32]          -
//  m_axis    out  pan_pwm[9:0], tilt_pwm[25:10], zero pad   pan_case[1:0]
//
// one word at a time; a bisecting pan rate runs ITERATIONS steps (24), each
// with three horner rounds, each split into a low and a high partial
// product in separate states before the accumulate
// zero and out of range pan rates skip the bisection
// the result sits in an output register, so a stalled m_axis only holds the
// next word in its finish state
// synchronous active-low reset clears the sequencer, output valid and held pan pwm
module rate_to_pwm_cubic_inverse_top import rtpci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // pan_rate, tilt_rate
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // pan_pwm, tilt_pwm, zero pad
    output logic [1:0]  o_m_axis_tuser    // pan_case
);

    t_cmd                    cmd;
    t_sts                    sts;
    logic signed [PWM_W-1:0] pan_pwm;
    logic [TILT_W-1:0]       tilt_pwm;
    logic [CASE_W-1:0]       pan_case;

    rtpci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rtpci_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pan_rate  ($signed(i_s_axis_tdata[31:0])),
        .i_tilt_rate ($signed(i_s_axis_tdata[63:32])),
        .o_pan_pwm   (pan_pwm),
        .o_tilt_pwm  (tilt_pwm),
        .o_pan_case  (pan_case)
    );

    assign o_m_axis_tdata = {6'b0, tilt_pwm, pan_pwm};
    assign o_m_axis_tuser = pan_case;

endmodule

// File: hdl/rtpci_chk.sv
// rtpci_chk: port-level checks on the rate to pwm cubic inverse top level,
// attached by bind. Uses rtpci_pkg for the pan case codes.
module rtpci_chk import rtpci_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [63:0] i_s_axis_tdata,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output word changed while stalled");

    // one word in flight: no accept right after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while a word is in work");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == CASE_RANGE) |->
            o_m_axis_tdata[9:0] == 10'd0)
        else $error("out of range pan rate gave nonzero pwm");

    // bisection result is at least 1.0, so a right turn is strictly positive
    a_right_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == CASE_RIGHT) |->
            !o_m_axis_tdata[9] && (o_m_axis_tdata[9:0] != 10'd0)
            && (o_m_axis_tdata[9:0] <= 10'd256))
        else $error("right turn pwm out of range");

    a_tilt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[25:10] <= 16'd32768)
        else $error("tilt pwm above saturation");

endmodule

bind rate_to_pwm_cubic_inverse_top rtpci_chk u_rtpci_chk (.*);
